// ===== rtl/btfq_pkg.sv =====
// ----------------------------------------------------------------------------
// btfq_pkg
// Shared constants, register indexes and the per-fault qualification step
// for the battery temperature fault qualifier.
// ----------------------------------------------------------------------------
package btfq_pkg;

	localparam int TEMP_W  = 8;
	localparam int IDX_W   = 8;
	localparam int SETC_W  = 2;
	localparam int CLRC_W  = 3;
	// compare width: threshold plus or minus the band never leaves this range
	localparam int CMP_W   = 10;

	localparam int SET_COUNT   = 2;
	localparam int CLEAR_COUNT = 6;
	localparam int HYSTERESIS  = 5;

	localparam logic [SETC_W-1:0]        SET_LIMIT  = SETC_W'(SET_COUNT);
	localparam logic [CLRC_W-1:0]        CLR_LIMIT  = CLRC_W'(CLEAR_COUNT);
	localparam logic signed [CMP_W-1:0]  HYST_BAND  = CMP_W'(HYSTERESIS);

	localparam logic signed [TEMP_W-1:0] CHARGE_MAX_RST    = 8'sd55;
	localparam logic signed [TEMP_W-1:0] DISCHARGE_MAX_RST = 8'sd65;
	localparam logic signed [TEMP_W-1:0] CHARGE_MIN_RST    = 8'sd0;
	localparam logic signed [TEMP_W-1:0] DISCHARGE_MIN_RST = -8'sd20;

	typedef enum logic [IDX_W-1:0] {
		REG_CHARGE_MAX    = 8'd0,
		REG_DISCHARGE_MAX = 8'd1,
		REG_CHARGE_MIN    = 8'd2,
		REG_DISCHARGE_MIN = 8'd3
	} cfg_reg_t;

	typedef struct packed {
		logic              flag;
		logic [SETC_W-1:0] cnt;
		logic [CLRC_W-1:0] clr;
	} chk_t;

	// one fault's update; the shared clear counter flows through in order
	function automatic chk_t run_check(
		input logic              flag,
		input logic [SETC_W-1:0] cnt,
		input logic [CLRC_W-1:0] clr,
		input logic              dir_ok,
		input logic              trip,
		input logic              reset_cnt,
		input logic              clr_ok
	);
		chk_t              r;
		logic [SETC_W-1:0] c_inc;
		logic [CLRC_W-1:0] k_inc;
		r.flag = flag;
		r.cnt  = cnt;
		r.clr  = clr;
		c_inc  = cnt + SETC_W'(1);
		k_inc  = clr + CLRC_W'(1);
		if (trip) begin
			if (!flag && dir_ok) begin
				if (c_inc >= SET_LIMIT) begin
					r.cnt  = '0;
					r.clr  = '0;
					r.flag = 1'b1;
				end else begin
					r.cnt = c_inc;
				end
			end
		end else if (reset_cnt) begin
			r.cnt = '0;
			if (flag && clr_ok) begin
				if (k_inc >= CLR_LIMIT) begin
					r.clr  = '0;
					r.flag = 1'b0;
				end else begin
					r.clr = k_inc;
				end
			end
		end
		return r;
	endfunction

endpackage

// ===== rtl/btfq_if.sv =====
// ----------------------------------------------------------------------------
// btfq interfaces
// Valid/ready channels for samples, fault results and register writes.
// ----------------------------------------------------------------------------
interface btfq_in_if;
	logic                                valid;
	logic                                ready;
	logic signed [btfq_pkg::TEMP_W-1:0]  max_temp;
	logic signed [btfq_pkg::TEMP_W-1:0]  min_temp;
	logic                                charging;
	logic                                system_active;

	modport source (output valid, max_temp, min_temp, charging, system_active,
		input ready);
	modport sink (input valid, max_temp, min_temp, charging, system_active,
		output ready);
endinterface

interface btfq_out_if;
	logic valid;
	logic ready;
	logic charge_overtemp_fault;
	logic discharge_overtemp_fault;
	logic charge_undertemp_fault;
	logic discharge_undertemp_fault;

	modport source (output valid, charge_overtemp_fault, discharge_overtemp_fault,
		charge_undertemp_fault, discharge_undertemp_fault, input ready);
	modport sink (input valid, charge_overtemp_fault, discharge_overtemp_fault,
		charge_undertemp_fault, discharge_undertemp_fault, output ready);
endinterface

interface btfq_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [btfq_pkg::IDX_W-1:0]        index;
	logic [btfq_pkg::TEMP_W-1:0]       data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/battery_temp_fault_qualifier_unit.sv =====
// ----------------------------------------------------------------------------
// battery_temp_fault_qualifier_unit
// Debounced over/under-temperature fault flags with hysteresis for a pack.
// ----------------------------------------------------------------------------
// Takes one temperature sample per clock when ready and returns one result
// beat per sample holding all four fault flags after that sample. A sample
// sits in an input register, then the four checks and the state update land
// in the result register; throughput is one sample per cycle while the
// output does not stall. Output stalls back-pressure the input only once
// both registers are full. Thresholds are written over the config channel
// (always ready); the user must write them only while no sample is in
// flight, which the block does not enforce. Unknown indexes are ignored.
module battery_temp_fault_qualifier_unit (
	input  logic   clk,
	input  logic   arst_n,
	btfq_in_if.sink    item_in,
	btfq_out_if.source result_out,
	btfq_cfg_if.sink   cfg
);

	localparam int TW = btfq_pkg::TEMP_W;
	localparam int CW = btfq_pkg::CMP_W;

	logic signed [TW-1:0] charge_max_q, discharge_max_q, charge_min_q, discharge_min_q;

	logic                 valid_s1;
	logic signed [TW-1:0] max_temp_s1, min_temp_s1;
	logic                 charging_s1, active_s1;

	logic                             valid_s2;
	logic [3:0]                       flags_s2;

	logic [3:0]                       flags_q;
	logic [btfq_pkg::SETC_W-1:0]      cnt_q [4];
	logic [btfq_pkg::CLRC_W-1:0]      clr_q;

	logic advance, load_s1;
	logic signed [CW-1:0] tmax, tmin, thr_cmax, thr_dmax, thr_cmin, thr_dmin;
	btfq_pkg::chk_t cot, dot, cut, dut;

	assign advance       = !valid_s2 || result_out.ready;
	assign item_in.ready = !valid_s1 || advance;
	assign load_s1       = item_in.valid && item_in.ready;
	assign cfg.ready     = 1'b1;

	assign tmax     = CW'(max_temp_s1);
	assign tmin     = CW'(min_temp_s1);
	assign thr_cmax = CW'(charge_max_q);
	assign thr_dmax = CW'(discharge_max_q);
	assign thr_cmin = CW'(charge_min_q);
	assign thr_dmin = CW'(discharge_min_q);

	// checks chained in fixed order through the shared clear counter
	always_comb begin
		cot = btfq_pkg::run_check(flags_q[0], cnt_q[0], clr_q, charging_s1,
			tmax >= thr_cmax, tmax < thr_cmax,
			tmax + btfq_pkg::HYST_BAND <= thr_cmax);
		dot = btfq_pkg::run_check(flags_q[1], cnt_q[1], cot.clr, !charging_s1,
			tmax >= thr_dmax, tmax < thr_dmax,
			tmax + btfq_pkg::HYST_BAND <= thr_dmax);
		cut = btfq_pkg::run_check(flags_q[2], cnt_q[2], dot.clr, charging_s1,
			tmin <= thr_cmin, tmin > thr_cmin + btfq_pkg::HYST_BAND,
			tmin > thr_cmin + btfq_pkg::HYST_BAND);
		dut = btfq_pkg::run_check(flags_q[3], cnt_q[3], cut.clr, !charging_s1,
			tmin <= thr_dmin, tmin > thr_dmin + btfq_pkg::HYST_BAND,
			tmin > thr_dmin + btfq_pkg::HYST_BAND);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			charge_max_q    <= btfq_pkg::CHARGE_MAX_RST;
			discharge_max_q <= btfq_pkg::DISCHARGE_MAX_RST;
			charge_min_q    <= btfq_pkg::CHARGE_MIN_RST;
			discharge_min_q <= btfq_pkg::DISCHARGE_MIN_RST;
		end else if (cfg.valid) begin
			unique case (btfq_pkg::cfg_reg_t'(cfg.index))
				btfq_pkg::REG_CHARGE_MAX:    charge_max_q    <= cfg.data;
				btfq_pkg::REG_DISCHARGE_MAX: discharge_max_q <= cfg.data;
				btfq_pkg::REG_CHARGE_MIN:    charge_min_q    <= cfg.data;
				btfq_pkg::REG_DISCHARGE_MIN: discharge_min_q <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_in.ready) begin
			valid_s1 <= item_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			max_temp_s1 <= item_in.max_temp;
			min_temp_s1 <= item_in.min_temp;
			charging_s1 <= item_in.charging;
			active_s1   <= item_in.system_active;
		end
	end

	// state update and result beat happen together
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			flags_s2 <= '0;
			flags_q  <= '0;
			clr_q    <= '0;
			for (int i = 0; i < 4; i++) begin
				cnt_q[i] <= '0;
			end
		end else if (advance) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				if (active_s1) begin
					flags_q  <= {dut.flag, cut.flag, dot.flag, cot.flag};
					flags_s2 <= {dut.flag, cut.flag, dot.flag, cot.flag};
					cnt_q[0] <= cot.cnt;
					cnt_q[1] <= dot.cnt;
					cnt_q[2] <= cut.cnt;
					cnt_q[3] <= dut.cnt;
					clr_q    <= dut.clr;
				end else begin
					flags_s2 <= flags_q;
				end
			end
		end
	end

	assign result_out.valid                     = valid_s2;
	assign result_out.charge_overtemp_fault     = flags_s2[0];
	assign result_out.discharge_overtemp_fault  = flags_s2[1];
	assign result_out.charge_undertemp_fault    = flags_s2[2];
	assign result_out.discharge_undertemp_fault = flags_s2[3];

endmodule
